/* rtl/waveform_min_max_rms_summary_macros.svh */
// Assertion macros for the waveform min/max/RMS summary block.
// Used by the top level only; no other dependencies.
`ifndef WAVEFORM_MIN_MAX_RMS_SUMMARY_MACROS_SVH
`define WAVEFORM_MIN_MAX_RMS_SUMMARY_MACROS_SVH

// ante implies cons in the same cycle
`define WMMRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// cond holds at every edge out of reset
`define WMMRS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

`endif

/* rtl/wmmrs_pkg.sv */
// Package for the waveform min/max/RMS summary block: widths, register
// indexes, segment record and queue status types, back end states.
`timescale 1ns / 1ps
`default_nettype none

package wmmrs_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int MAX_WIDTH    = 15;
	localparam int RMS_WIDTH    = 16;
	localparam int SUM_WIDTH    = 50;
	localparam int COUNT_WIDTH  = 20;
	localparam int MEAN_WIDTH   = 31;
	localparam int FRAMES_WIDTH = 16;
	localparam int CHAN_WIDTH   = 4;
	localparam int CFG_WIDTH    = 16;
	localparam int CFG_IDX_W    = 1;

	localparam int DEF_MAX_CHANNELS = 8;
	localparam int DEF_QUEUE_DEPTH  = 4;

	localparam logic [FRAMES_WIDTH-1:0] FRAMES_RESET = 16'd441;
	localparam logic [CHAN_WIDTH-1:0]   CHANS_RESET  = 4'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_SEGMENT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT       = 1'd1;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] seg_min;
		logic [MAX_WIDTH-1:0]           seg_max;
		logic [SUM_WIDTH-1:0]           sum;
		logic [COUNT_WIDTH-1:0]         count;
		logic                           eod;
	} seg_rec_t;

	typedef struct packed {
		logic full;
		logic valid;
	} q_stat_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_SQRT,
		B_DONE
	} b_state_t;

endpackage

`default_nettype wire

/* rtl/wmmrs_front.sv */
// Front end: configuration registers, per-segment min/max/sum of squares
// accumulation and segment close detection. Depends on wmmrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wmmrs_front import wmmrs_pkg::*; #(
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [CFG_IDX_W-1:0]           cfg_index,
	input  wire logic [CFG_WIDTH-1:0]           cfg_data,
	input  wire logic                           in_valid,
	output      logic                           in_stall,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
	input  wire logic                           end_of_data,
	input  wire q_stat_t                        q_stat,
	output      logic                           push,
	output      seg_rec_t                       rec
);

	logic [FRAMES_WIDTH-1:0]        frames_q;
	logic [CHAN_WIDTH-1:0]          chans_q;
	logic signed [SAMPLE_WIDTH-1:0] min_q;
	logic [MAX_WIDTH-1:0]           max_q;
	logic [SUM_WIDTH-1:0]           sum_q;
	logic [COUNT_WIDTH-1:0]         cnt_q;

	logic [FRAMES_WIDTH-1:0]        frames_eff;
	logic [CHAN_WIDTH-1:0]          chans_eff;
	logic [COUNT_WIDTH-1:0]         target;
	logic signed [31:0]             sq;
	logic signed [SAMPLE_WIDTH-1:0] min_next;
	logic [MAX_WIDTH-1:0]           max_next;
	logic [SUM_WIDTH-1:0]           sum_next;
	logic [COUNT_WIDTH-1:0]         cnt_next;
	logic                           take;
	logic                           close;

	assign in_stall = q_stat.full;
	assign take     = in_valid && !q_stat.full;

	always_comb begin
		frames_eff = (frames_q == '0) ? FRAMES_WIDTH'(1) : frames_q;
		if (chans_q == '0) begin
			chans_eff = CHAN_WIDTH'(1);
		end else if (32'(chans_q) > MAX_CHANNELS) begin
			chans_eff = CHAN_WIDTH'(MAX_CHANNELS);
		end else begin
			chans_eff = chans_q;
		end
	end

	assign target   = {{(COUNT_WIDTH-FRAMES_WIDTH){1'b0}}, frames_eff}
	                * {{(COUNT_WIDTH-CHAN_WIDTH){1'b0}}, chans_eff};
	assign sq       = sample * sample;
	assign min_next = (sample < min_q) ? sample : min_q;
	assign max_next = (sample > $signed({1'b0, max_q})) ? sample[MAX_WIDTH-1:0] : max_q;
	assign sum_next = sum_q + {{(SUM_WIDTH-MEAN_WIDTH){1'b0}}, sq[MEAN_WIDTH-1:0]};
	assign cnt_next = cnt_q + COUNT_WIDTH'(1);
	assign close    = end_of_data || (cnt_next >= target) || (cnt_next == '0);
	assign push     = take && close;

	always_comb begin
		rec.seg_min = min_next;
		rec.seg_max = max_next;
		rec.sum     = sum_next;
		rec.count   = cnt_next;
		rec.eod     = end_of_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RESET;
			chans_q  <= CHANS_RESET;
			min_q    <= '0;
			max_q    <= '0;
			sum_q    <= '0;
			cnt_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SAMPLES_PER_SEGMENT: frames_q <= cfg_data[FRAMES_WIDTH-1:0];
					REG_CHANNEL_COUNT:       chans_q  <= cfg_data[CHAN_WIDTH-1:0];
					default:                 frames_q <= frames_q;
				endcase
			end
			if (take) begin
				if (close) begin
					min_q <= '0;
					max_q <= '0;
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					min_q <= min_next;
					max_q <= max_next;
					sum_q <= sum_next;
					cnt_q <= cnt_next;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/wmmrs_queue.sv */
// Segment record queue between front and back end; small register file
// with wrap-around pointers. Depends on wmmrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wmmrs_queue import wmmrs_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire seg_rec_t wr_rec,
	input  wire logic     pop,
	output      seg_rec_t rd_rec,
	output      q_stat_t  q_stat
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	seg_rec_t         slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	assign rd_rec       = slots_q[rd_ptr_q];
	assign q_stat.full  = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign q_stat.valid = (fill_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + CNT_W'(1);
				2'b01:   fill_q <= fill_q - CNT_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/wmmrs_back.sv */
// Back end: bit-serial divide of the sum of squares by the count, digit
// serial square root, then the result output register. Depends on wmmrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wmmrs_back import wmmrs_pkg::*; (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire q_stat_t                        q_stat,
	input  wire seg_rec_t                       rd_rec,
	output      logic                           pop,
	output      logic                           out_valid,
	input  wire logic                           out_stall,
	output      logic signed [SAMPLE_WIDTH-1:0] segment_min,
	output      logic [MAX_WIDTH-1:0]           segment_max,
	output      logic [RMS_WIDTH-1:0]           segment_rms,
	output      logic                           last_segment
);

	localparam int DIV_STEPS  = SUM_WIDTH;
	localparam int SQRT_STEPS = (MEAN_WIDTH + 1) / 2;
	localparam int STEP_W     = $clog2(DIV_STEPS);
	localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);
	localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQRT_STEPS - 1);
	localparam logic [MEAN_WIDTH-1:0] BIT_TOP = MEAN_WIDTH'(1) << (MEAN_WIDTH - 1);

	b_state_t state_q;
	b_state_t state_next;
	logic     out_load;
	logic     out_valid_q;

	logic [STEP_W-1:0]              step_q;
	logic [COUNT_WIDTH:0]           rem_q;
	logic [SUM_WIDTH-1:0]           quo_q;
	logic [COUNT_WIDTH-1:0]         cnt_q;
	logic [MEAN_WIDTH-1:0]          x_q;
	logic [MEAN_WIDTH:0]            root_q;
	logic [MEAN_WIDTH-1:0]          bit_q;
	logic signed [SAMPLE_WIDTH-1:0] min_q;
	logic [MAX_WIDTH-1:0]           max_q;
	logic                           eod_q;

	logic [COUNT_WIDTH:0]   div_try;
	logic                   div_ge;
	logic [COUNT_WIDTH:0]   rem_next;
	logic [SUM_WIDTH-1:0]   quo_next;
	logic [MEAN_WIDTH:0]    trial;
	logic                   sq_ge;
	logic [MEAN_WIDTH:0]    root_next;

	assign div_try  = {rem_q[COUNT_WIDTH-1:0], quo_q[SUM_WIDTH-1]};
	assign div_ge   = div_try >= {1'b0, cnt_q};
	assign rem_next = div_ge ? div_try - {1'b0, cnt_q} : div_try;
	assign quo_next = {quo_q[SUM_WIDTH-2:0], div_ge};

	assign trial     = root_q + {1'b0, bit_q};
	assign sq_ge     = {1'b0, x_q} >= trial;
	assign root_next = sq_ge ? (root_q >> 1) + {1'b0, bit_q} : root_q >> 1;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			B_IDLE: if (q_stat.valid) state_next = B_DIV;
			B_DIV:  if (step_q == DIV_LAST) state_next = B_SQRT;
			B_SQRT: if (step_q == SQRT_LAST) state_next = B_DONE;
			B_DONE: if (!out_valid_q || !out_stall) state_next = B_IDLE;
			default: state_next = B_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			B_IDLE:  pop      = q_stat.valid;
			B_DONE:  out_load = !out_valid_q || !out_stall;
			default: begin
				pop      = 1'b0;
				out_load = 1'b0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_q != state_next) begin
				step_q <= '0;
			end else begin
				step_q <= step_q + STEP_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				rem_q <= '0;
				quo_q <= rd_rec.sum;
				cnt_q <= rd_rec.count;
				min_q <= rd_rec.seg_min;
				max_q <= rd_rec.seg_max;
				eod_q <= rd_rec.eod;
			end
			B_DIV: begin
				rem_q  <= rem_next;
				quo_q  <= quo_next;
				x_q    <= quo_next[MEAN_WIDTH-1:0];
				root_q <= '0;
				bit_q  <= BIT_TOP;
			end
			B_SQRT: begin
				if (sq_ge) begin
					x_q <= x_q - trial[MEAN_WIDTH-1:0];
				end
				root_q <= root_next;
				bit_q  <= bit_q >> 2;
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
		if (out_load) begin
			segment_min  <= min_q;
			segment_max  <= max_q;
			segment_rms  <= root_q[RMS_WIDTH-1:0];
			last_segment <= eod_q;
		end
	end

endmodule

`default_nettype wire

/* rtl/waveform_min_max_rms_summary.sv */
// Waveform overview summary: one sample in per cycle when not stalled, one
// min/max/RMS result out per closed segment. Input samples of all channels
// of a segment arrive on in_valid/in_stall, results leave on out_valid/out_stall.
// Configuration (samples_per_segment, channel_count) goes through the plain
// write port cfg_we/cfg_index/cfg_data while the block is idle; it takes
// effect on the next sample.
// Throughput: a sample is taken every cycle while the segment queue has room.
// A closed segment occupies the back end while it loads the record, runs the
// restoring divide, one bit a cycle, and the square root, two bits a cycle,
// and loads the output register; it pops the next record only when idle, so
// segments that close faster than this fill the queue and then in_stall
// rises until the back end drains a record. A stalled result holds in the
// output register; the back end keeps working on the next record and waits
// only for that register.
// Reset clears the running sums, the queue and out_valid, and sets the
// registers to 441 frames and 2 channels.
`timescale 1ns / 1ps
`default_nettype none
`include "waveform_min_max_rms_summary_macros.svh"

module waveform_min_max_rms_summary import wmmrs_pkg::*; #(
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
	parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [CFG_IDX_W-1:0]           cfg_index,
	input  wire logic [CFG_WIDTH-1:0]           cfg_data,
	input  wire logic                           in_valid,
	output      logic                           in_stall,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
	input  wire logic                           end_of_data,
	output      logic                           out_valid,
	input  wire logic                           out_stall,
	output      logic signed [SAMPLE_WIDTH-1:0] segment_min,
	output      logic [MAX_WIDTH-1:0]           segment_max,
	output      logic [RMS_WIDTH-1:0]           segment_rms,
	output      logic                           last_segment
);

	q_stat_t  q_stat;
	logic     push;
	logic     pop;
	seg_rec_t wr_rec;
	seg_rec_t rd_rec;

	wmmrs_front #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.end_of_data (end_of_data),
		.q_stat      (q_stat),
		.push        (push),
		.rec         (wr_rec)
	);

	wmmrs_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (wr_rec),
		.pop    (pop),
		.rd_rec (rd_rec),
		.q_stat (q_stat)
	);

	wmmrs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.rd_rec       (rd_rec),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.segment_min  (segment_min),
		.segment_max  (segment_max),
		.segment_rms  (segment_rms),
		.last_segment (last_segment)
	);

	`WMMRS_ASSERT_IMP(a_push_not_full, clk, arst_n, push, !q_stat.full, "transfer into full queue")
	`WMMRS_ASSERT_IMP(a_pop_not_empty, clk, arst_n, pop, q_stat.valid, "pop from empty queue")
	`WMMRS_ASSERT_IMP(a_rec_count, clk, arst_n, push, wr_rec.count != '0, "empty segment closed")
	`WMMRS_ASSERT_IMP(a_rms_range, clk, arst_n, out_valid, segment_rms <= 16'd32768, "rms out of range")

endmodule

`default_nettype wire

/* bench/waveform_min_max_rms_summary_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the waveform min/max/RMS summary: follows register writes and sample
// transfers, predicts each closed segment and compares every result transfer.
// Depends on wmmrs_pkg for widths and register indexes.
module waveform_min_max_rms_summary_checker import wmmrs_pkg::*; (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [CFG_IDX_W-1:0]           cfg_index,
	input  wire logic [CFG_WIDTH-1:0]           cfg_data,
	input  wire logic                           in_valid,
	input  wire logic                           in_stall,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
	input  wire logic                           end_of_data,
	input  wire logic                           out_valid,
	input  wire logic                           out_stall,
	input  wire logic signed [SAMPLE_WIDTH-1:0] segment_min,
	input  wire logic [MAX_WIDTH-1:0]           segment_max,
	input  wire logic [RMS_WIDTH-1:0]           segment_rms,
	input  wire logic                           last_segment,
	output int                                  pending,
	output int                                  failures,
	output int                                  segments
);

	typedef struct {
		logic signed [SAMPLE_WIDTH-1:0] lo;
		logic [MAX_WIDTH-1:0]           hi;
		logic [RMS_WIDTH-1:0]           rms;
		logic                           last;
	} seg_summary_t;

	seg_summary_t seg_expect_q[$];

	logic [FRAMES_WIDTH-1:0]        frames_reg = FRAMES_RESET;
	logic [CHAN_WIDTH-1:0]          chans_reg  = CHANS_RESET;
	logic signed [SAMPLE_WIDTH-1:0] run_lo = '0;
	logic signed [SAMPLE_WIDTH-1:0] run_hi = '0;
	logic [SUM_WIDTH-1:0]           run_sq = '0;
	logic [COUNT_WIDTH-1:0]         run_n  = '0;
	int                             mism = 0;
	int                             seen = 0;

	function automatic logic [RMS_WIDTH-1:0] floor_root(input logic [SUM_WIDTH-1:0] x);
		logic [63:0] r;
		logic [63:0] trial;
		r = '0;
		for (int i = RMS_WIDTH - 1; i >= 0; i--) begin
			trial = r | (64'd1 << i);
			if (trial * trial <= 64'(x))
				r = trial;
		end
		return RMS_WIDTH'(r);
	endfunction

	task automatic take_sample(input logic signed [SAMPLE_WIDTH-1:0] s, input logic eod);
		logic [39:0]       frames;
		logic [39:0]       chans;
		logic [39:0]       target;
		logic signed [31:0] sq;
		seg_summary_t      r;
		frames = (frames_reg == '0) ? 40'd1 : 40'(frames_reg);
		if (chans_reg == '0)
			chans = 40'd1;
		else if (chans_reg > DEF_MAX_CHANNELS)
			chans = 40'(DEF_MAX_CHANNELS);
		else
			chans = 40'(chans_reg);
		target = frames * chans;
		if (s < run_lo)
			run_lo = s;
		if (s > run_hi)
			run_hi = s;
		sq = s * s;
		run_sq = run_sq + SUM_WIDTH'($unsigned(sq));
		run_n = run_n + 1'b1;
		if (eod || 40'(run_n) >= target) begin
			r.lo   = run_lo;
			r.hi   = run_hi[MAX_WIDTH-1:0];
			r.rms  = floor_root(run_sq / run_n);
			r.last = eod;
			seg_expect_q.push_back(r);
			run_lo = '0;
			run_hi = '0;
			run_sq = '0;
			run_n  = '0;
		end
	endtask

	task automatic check_result();
		seg_summary_t e;
		seen++;
		if (seg_expect_q.size() == 0) begin
			mism++;
			$display("%0t: unexpected result min %0d max %0d rms %0d last %0b", $time,
				segment_min, segment_max, segment_rms, last_segment);
		end else begin
			e = seg_expect_q.pop_front();
			if (segment_min !== e.lo) begin
				mism++;
				$display("%0t: segment_min expected %0d got %0d", $time, e.lo, segment_min);
			end
			if (segment_max !== e.hi) begin
				mism++;
				$display("%0t: segment_max expected %0d got %0d", $time, e.hi, segment_max);
			end
			if (segment_rms !== e.rms) begin
				mism++;
				$display("%0t: segment_rms expected %0d got %0d", $time, e.rms, segment_rms);
			end
			if (last_segment !== e.last) begin
				mism++;
				$display("%0t: last_segment expected %0b got %0b", $time, e.last,
					last_segment);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_reg = FRAMES_RESET;
			chans_reg  = CHANS_RESET;
			run_lo = '0;
			run_hi = '0;
			run_sq = '0;
			run_n  = '0;
			seg_expect_q.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			if (in_valid && !in_stall)
				take_sample(sample, end_of_data);
			if (cfg_we) begin
				if (cfg_index == REG_SAMPLES_PER_SEGMENT)
					frames_reg = cfg_data[FRAMES_WIDTH-1:0];
				else if (cfg_index == REG_CHANNEL_COUNT)
					chans_reg = cfg_data[CHAN_WIDTH-1:0];
			end
			pending  <= seg_expect_q.size();
			failures <= mism;
			segments <= seen;
		end
	end

endmodule

/* bench/waveform_min_max_rms_summary_test.sv */
`timescale 1ns / 1ps
// Top of the bench for the waveform min/max/RMS summary: clock, reset, register set-up,
// directed and random sample transfers and the verdict; checking sits in the checker module.
// Depends on wmmrs_pkg, the block and waveform_min_max_rms_summary_checker.
module waveform_min_max_rms_summary_test;
	import wmmrs_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 100;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]           cfg_index = '0;
	logic [CFG_WIDTH-1:0]           cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic signed [SAMPLE_WIDTH-1:0] sample = '0;
	logic                           end_of_data = 1'b0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic signed [SAMPLE_WIDTH-1:0] segment_min;
	logic [MAX_WIDTH-1:0]           segment_max;
	logic [RMS_WIDTH-1:0]           segment_rms;
	logic                           last_segment;

	int pending, failures, segments;
	int send_pct = 0;
	int recv_pct = 0;
	int sent = 0;
	int settings = 0;
	int cycles = 0;

	waveform_min_max_rms_summary dut (.*);

	waveform_min_max_rms_summary_checker chk (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < recv_pct);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic push(input logic signed [SAMPLE_WIDTH-1:0] s, input logic eod);
		while ($urandom_range(0, 99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		sample      <= s;
		end_of_data <= eod;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_WIDTH-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// quiet the block fully, then load both registers; upper data bits of the
	// channel write are junk the block must ignore
	task automatic configure(input logic [FRAMES_WIDTH-1:0] frames,
			input logic [CHAN_WIDTH-1:0] chans);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_SAMPLES_PER_SEGMENT, frames);
		write_reg(REG_CHANNEL_COUNT, {12'($urandom), chans});
		repeat (4) @(posedge clk);
		settings++;
	endtask

	function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return '0;
			3: return SAMPLE_WIDTH'($urandom_range(0, 16)) - 16'sd8;
			default: return SAMPLE_WIDTH'($urandom);
		endcase
	endfunction

	task automatic set_idle(input int s, input int r);
		send_pct = s;
		recv_pct <= r;
	endtask

	initial begin
		int p;
		int k;
		int n;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idle(38, 87);

		// reset settings, segment closed early by end of data
		push(-16'sd32768, 1'b0);
		push(16'sd32767, 1'b0);
		push(16'sd0, 1'b1);
		// one sample per segment
		configure(16'd1, 4'd1);
		push(-16'sd1, 1'b0);
		push(16'sd1, 1'b0);
		push(16'sd0, 1'b0);
		// zero length and zero channels count as one
		configure(16'd0, 4'd0);
		push(16'h5555, 1'b0);
		push(16'haaaa, 1'b0);
		// channel count above the maximum saturates
		configure(16'd1, 4'd15);
		for (n = 0; n < 9; n++)
			push(SAMPLE_WIDTH'(n * 7919 - 30000), n == 8);
		// longest possible segment, closed by end of data
		configure(16'd65535, 4'd8);
		push(16'sd32767, 1'b0);
		push(-16'sd32768, 1'b1);
		// last sample also fills the segment
		configure(16'd2, 4'd1);
		push(16'sd100, 1'b0);
		push(-16'sd100, 1'b1);
		// target lowered below the count of an open segment
		configure(16'd2, 4'd2);
		push(16'sd300, 1'b0);
		push(-16'sd20000, 1'b0);
		push(16'sd12345, 1'b0);
		configure(16'd1, 4'd1);
		push(16'sd7, 1'b0);

		for (p = 0; p < 3; p++) begin
			if (p == 0)
				set_idle(38, 87);
			else if (p == 1)
				set_idle(87, 38);
			else
				set_idle(0, 0);
			for (k = 0; k < 2; k++) begin
				if (k == 0)
					configure(FRAMES_WIDTH'($urandom_range(1, 6)),
						CHAN_WIDTH'($urandom_range(0, 15)));
				else if (p == 0)
					configure(FRAMES_RESET, CHANS_RESET);
				else if (p == 1)
					configure(FRAMES_WIDTH'($urandom), CHAN_WIDTH'($urandom_range(0, 15)));
				else
					configure(16'd1, 4'd1);
				for (n = 0; n < 200; n++) begin
					push(pick_sample(), $urandom_range(0, 99) < 3);
					if ($urandom_range(0, 199) == 0)
						drain_results();
				end
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d sample transfers under %0d register settings and three idling mixes",
			sent, settings);
		$display("%0d segment results compared, %0d mismatches", segments, failures);
		if (failures == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/wmmrs_pkg.sv
rtl/wmmrs_front.sv
rtl/wmmrs_queue.sv
rtl/wmmrs_back.sv
rtl/waveform_min_max_rms_summary.sv
bench/waveform_min_max_rms_summary_checker.sv
bench/waveform_min_max_rms_summary_test.sv
